>>> hdl/qrs_pkg.sv
// ----------------------------------------------------------------------------
// qrs_pkg
// Shared constants and types for the quadratic root solver.
// ----------------------------------------------------------------------------
package qrs_pkg;

  localparam int COEF_WIDTH_DEF = 16;
  localparam int FRAC_BITS_DEF  = 8;

  localparam int IN_W   = 16;  // coefficient field width
  localparam int EXT_W  = 17;  // internal coefficient width
  localparam int DISC_W = 34;
  localparam int ROOT_W = 25;

  localparam logic [ROOT_W-1:0] ROOT_MAX = {1'b0, {(ROOT_W-1){1'b1}}};
  localparam logic [ROOT_W-1:0] ROOT_MIN = {1'b1, {(ROOT_W-1){1'b0}}};

  typedef enum logic [1:0] {
    ST_REAL    = 2'd0,
    ST_NO_ROOT = 2'd1,
    ST_DEGEN   = 2'd2
  } status_e;

endpackage

>>> hdl/qrs_req_if.sv
// ----------------------------------------------------------------------------
// qrs_req_if
// Request channel: one set of coefficients.
// ----------------------------------------------------------------------------
interface qrs_req_if;
  logic                             valid;
  logic                             ready;
  logic signed [qrs_pkg::IN_W-1:0]  coef_a;
  logic signed [qrs_pkg::IN_W-1:0]  coef_b;
  logic signed [qrs_pkg::IN_W-1:0]  coef_c;

  modport source (output valid, output coef_a, output coef_b, output coef_c, input ready);
  modport sink   (input valid, input coef_a, input coef_b, input coef_c, output ready);
endinterface

>>> hdl/qrs_rsp_if.sv
// ----------------------------------------------------------------------------
// qrs_rsp_if
// Result channel: status, discriminant and both roots.
// ----------------------------------------------------------------------------
interface qrs_rsp_if;
  logic                               valid;
  logic                               ready;
  logic [1:0]                         status;
  logic signed [qrs_pkg::DISC_W-1:0]  discriminant;
  logic signed [qrs_pkg::ROOT_W-1:0]  root_plus;
  logic signed [qrs_pkg::ROOT_W-1:0]  root_minus;

  modport source (output valid, output status, output discriminant, output root_plus,
                  output root_minus, input ready);
  modport sink   (input valid, input status, input discriminant, input root_plus,
                  input root_minus, output ready);
endinterface

>>> hdl/qrs_div_pipe.sv
// ----------------------------------------------------------------------------
// qrs_div_pipe
// Pipelined unsigned restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module qrs_div_pipe #(
  parameter int NUM_W = 28,
  parameter int DEN_W = 18
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic [NUM_W-1:0] quo_o
);

  logic [NUM_W-1:0] dvd_q [1:NUM_W];
  logic [DEN_W-1:0] rem_q [1:NUM_W];
  logic [DEN_W-1:0] den_q [1:NUM_W];

  for (genvar k = 0; k < NUM_W; k++) begin : g_stage
    logic [NUM_W-1:0] dvd_s;
    logic [DEN_W-1:0] rem_s;
    logic [DEN_W-1:0] den_s;
    logic [DEN_W:0]   rn;
    logic [DEN_W:0]   sub;
    logic             ge;

    if (k == 0) begin : g_first
      assign dvd_s = num_i;
      assign rem_s = '0;
      assign den_s = den_i;
    end else begin : g_rest
      assign dvd_s = dvd_q[k];
      assign rem_s = rem_q[k];
      assign den_s = den_q[k];
    end

    assign rn  = {rem_s, dvd_s[NUM_W-1]};
    assign sub = rn - {1'b0, den_s};
    assign ge  = (rn >= {1'b0, den_s});

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k+1] <= ge ? sub[DEN_W-1:0] : rn[DEN_W-1:0];
        dvd_q[k+1] <= {dvd_s[NUM_W-2:0], ge};
        den_q[k+1] <= den_s;
      end
    end
  end

  assign quo_o = dvd_q[NUM_W];

endmodule

>>> hdl/quadratic_root_solver_unit.sv
// Request path: input and product stages, discriminant stage, square root, numerators, dividers, result register.
// Throughput: one request per cycle unless the result stalls; square root and both
// dividers are fully pipelined, one root bit or quotient bit per stage.
// A stalled result freezes the whole pipeline; nothing is dropped or repeated.
// Reset clears all valid bits at once; no clearing pass.
// ----------------------------------------------------------------------------
// quadratic_root_solver_unit
// Real roots of a*x^2 + b*x + c in fixed point: discriminant, digit-by-digit
// square root, then two rounded restoring dividers with saturation.
// ----------------------------------------------------------------------------
module quadratic_root_solver_unit #(
  parameter int COEF_WIDTH = qrs_pkg::COEF_WIDTH_DEF,
  parameter int FRAC_BITS  = qrs_pkg::FRAC_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  qrs_req_if.sink    req_i,
  qrs_rsp_if.source  rsp_o
);

  localparam int IN_W   = qrs_pkg::IN_W;
  localparam int EXT_W  = qrs_pkg::EXT_W;
  localparam int DISC_W = qrs_pkg::DISC_W;
  localparam int ROOT_W = qrs_pkg::ROOT_W;
  localparam int DW     = 36;
  localparam int RB     = 18 + FRAC_BITS;
  localparam int RADW   = 2 * RB;
  localparam int NW     = RB + 3;
  localparam int MW     = RB + 2;
  localparam int DV     = EXT_W + 1;
  localparam int LAST   = RB + 1 + MW;
  localparam int SB     = (COEF_WIDTH > IN_W) ? IN_W - 1 : COEF_WIDTH - 1;
  localparam bit SGN    = (COEF_WIDTH <= IN_W);
  localparam int CMPW   = (MW > ROOT_W + 1) ? MW : ROOT_W + 1;
  localparam logic [CMPW-1:0] LIM = CMPW'(1) << (ROOT_W - 1);

  typedef struct packed {
    qrs_pkg::status_e          status;
    logic [DISC_W-1:0]         disc;
    logic signed [EXT_W-1:0]   a;
    logic signed [EXT_W-1:0]   b;
    logic                      negp;
    logic                      negm;
  } side_t;

  function automatic logic signed [EXT_W-1:0] ext(input logic [IN_W-1:0] x);
    logic [EXT_W-1:0] e;
    for (int i = 0; i < IN_W; i++) begin
      e[i] = (i <= SB) ? x[i] : (SGN ? x[SB] : 1'b0);
    end
    e[EXT_W-1] = SGN ? x[SB] : 1'b0;
    return signed'(e);
  endfunction

  function automatic logic [ROOT_W-1:0] sat(input logic [MW-1:0] q, input logic neg);
    logic [CMPW-1:0]   qe;
    logic [ROOT_W-1:0] r;
    qe = CMPW'(q);
    if (neg) begin
      r = (qe > LIM) ? qrs_pkg::ROOT_MIN : ~qe[ROOT_W-1:0] + 1'b1;
    end else begin
      r = (qe > LIM - 1'b1) ? qrs_pkg::ROOT_MAX : qe[ROOT_W-1:0];
    end
    return r;
  endfunction

  logic en;

  logic                          vld0_q, vld1_q;
  logic signed [EXT_W-1:0]       a0_q, b0_q, c0_q, a1_q, b1_q;
  logic signed [2*EXT_W-1:0]     bb_q, ac_q;
  logic signed [DW-1:0]          d_c;
  side_t                         side_d;

  logic                          vld_q  [0:LAST];
  side_t                         side_q [0:LAST];
  logic [RADW-1:0]               rad_q  [0:RB];
  logic [RB+1:0]                 rem_q  [0:RB];
  logic [RB-1:0]                 root_q [0:RB];

  logic [MW-1:0]                 nump_q, numm_q, quo_p, quo_m;
  logic [DV-1:0]                 den_q;

  logic                          out_vld_q;
  qrs_pkg::status_e              status_q;
  logic [DISC_W-1:0]             disc_q;
  logic [ROOT_W-1:0]             rp_q, rm_q;

  assign en          = !out_vld_q || rsp_o.ready;
  assign req_i.ready = en;

  // input and product stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld0_q <= 1'b0;
      vld1_q <= 1'b0;
    end else if (en) begin
      vld0_q <= req_i.valid;
      vld1_q <= vld0_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a0_q <= ext(req_i.coef_a);
      b0_q <= ext(req_i.coef_b);
      c0_q <= ext(req_i.coef_c);
      bb_q <= b0_q * b0_q;
      ac_q <= a0_q * c0_q;
      a1_q <= a0_q;
      b1_q <= b0_q;
    end
  end

  // discriminant stage
  always_comb begin
    d_c         = DW'(bb_q) - (DW'(ac_q) <<< 2);
    side_d      = '0;
    side_d.disc = d_c[DISC_W-1:0];
    side_d.a    = a1_q;
    side_d.b    = b1_q;
    if (a1_q == '0) begin
      side_d.status = qrs_pkg::ST_DEGEN;
    end else if (d_c[DW-1]) begin
      side_d.status = qrs_pkg::ST_NO_ROOT;
    end else begin
      side_d.status = qrs_pkg::ST_REAL;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (en) begin
      vld_q[0] <= vld1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_q[0] <= side_d;
      rad_q[0]  <= RADW'(unsigned'(d_c)) << (2 * FRAC_BITS);
      rem_q[0]  <= '0;
      root_q[0] <= '0;
    end
  end

  // square root, one root bit per stage
  for (genvar k = 0; k < RB; k++) begin : g_sqrt
    logic [RB+1:0] rn, tr;
    logic          ge;

    assign rn = {rem_q[k][RB-1:0], rad_q[k][RADW-1 -: 2]};
    assign tr = {root_q[k], 2'b01};
    assign ge = (rn >= tr);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k+1] <= 1'b0;
      end else if (en) begin
        vld_q[k+1] <= vld_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        rad_q[k+1]  <= rad_q[k] << 2;
        rem_q[k+1]  <= ge ? rn - tr : rn;
        root_q[k+1] <= {root_q[k][RB-2:0], ge};
        side_q[k+1] <= side_q[k];
      end
    end
  end

  // numerators: |N| + |a| for rounding, divisor 2|a|
  logic signed [NW-1:0] nb, np, nm;
  logic [NW-1:0]        abp, abm;
  logic [EXT_W-1:0]     aa;
  side_t                side_n;

  always_comb begin
    nb  = -(NW'(side_q[RB].b) <<< FRAC_BITS);
    np  = nb + signed'(NW'(root_q[RB]));
    nm  = nb - signed'(NW'(root_q[RB]));
    abp = np[NW-1] ? NW'(-np) : NW'(np);
    abm = nm[NW-1] ? NW'(-nm) : NW'(nm);
    aa  = side_q[RB].a[EXT_W-1] ? EXT_W'(-side_q[RB].a) : EXT_W'(side_q[RB].a);
    side_n      = side_q[RB];
    side_n.negp = np[NW-1] ^ side_q[RB].a[EXT_W-1];
    side_n.negm = nm[NW-1] ^ side_q[RB].a[EXT_W-1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[RB+1] <= 1'b0;
    end else if (en) begin
      vld_q[RB+1] <= vld_q[RB];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_q[RB+1] <= side_n;
      nump_q       <= MW'(abp) + MW'(aa);
      numm_q       <= MW'(abm) + MW'(aa);
      den_q        <= {aa, 1'b0};
    end
  end

  qrs_div_pipe #(.NUM_W(MW), .DEN_W(DV)) u_div_plus (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (nump_q),
    .den_i (den_q),
    .quo_o (quo_p)
  );

  qrs_div_pipe #(.NUM_W(MW), .DEN_W(DV)) u_div_minus (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (numm_q),
    .den_i (den_q),
    .quo_o (quo_m)
  );

  for (genvar k = RB + 1; k < LAST; k++) begin : g_side
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k+1] <= 1'b0;
      end else if (en) begin
        vld_q[k+1] <= vld_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        side_q[k+1] <= side_q[k];
      end
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= vld_q[LAST];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      status_q <= side_q[LAST].status;
      disc_q   <= side_q[LAST].disc;
      if (side_q[LAST].status == qrs_pkg::ST_REAL) begin
        rp_q <= sat(quo_p, side_q[LAST].negp);
        rm_q <= sat(quo_m, side_q[LAST].negm);
      end else begin
        rp_q <= '0;
        rm_q <= '0;
      end
    end
  end

  assign rsp_o.valid        = out_vld_q;
  assign rsp_o.status       = status_q;
  assign rsp_o.discriminant = signed'(disc_q);
  assign rsp_o.root_plus    = signed'(rp_q);
  assign rsp_o.root_minus   = signed'(rm_q);

  a_no_root_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && rsp_o.status != qrs_pkg::ST_REAL |->
      rsp_o.root_plus == '0 && rsp_o.root_minus == '0)
    else $error("roots not cleared for non-real status");

  a_stall_blocks : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && !rsp_o.ready |-> !req_i.ready)
    else $error("request taken while result stalled");

  a_out_from_pipe : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> $past(vld_q[LAST]))
    else $error("result valid without a pipeline entry");

endmodule

>>> tb/sv/tb_quadratic_root_solver_unit.sv
// ----------------------------------------------------------------------------
// tb_quadratic_root_solver_unit
// Drives coefficient requests with random idling and back-pressure, predicts
// status, discriminant and both rounded roots, and checks results in order.
// ----------------------------------------------------------------------------
module tb_quadratic_root_solver_unit;

  typedef struct packed {
    logic [1:0]                        status;
    logic signed [qrs_pkg::DISC_W-1:0] disc;
    logic signed [qrs_pkg::ROOT_W-1:0] rp;
    logic signed [qrs_pkg::ROOT_W-1:0] rm;
  } roots_t;

  class root_scoreboard;
    roots_t pending_q[$];
    int     n_err;

    function longint unsigned isqrt_scaled(longint unsigned d);
      longint unsigned rem, root, pair, trial;
      rem = 0;
      root = 0;
      for (int i = 31 + qrs_pkg::FRAC_BITS_DEF; i >= 0; i--) begin
        pair = (i >= qrs_pkg::FRAC_BITS_DEF) ?
               ((d >> (2 * (i - qrs_pkg::FRAC_BITS_DEF))) & 3) : 0;
        rem = (rem << 2) | pair;
        trial = (root << 2) | 1;
        if (rem >= trial) begin
          rem -= trial;
          root = (root << 1) | 1;
        end else begin
          root = root << 1;
        end
      end
      return root;
    endfunction

    function longint div_round_sat(longint num, longint den);
      bit neg;
      longint unsigned un, ud, q;
      neg = (num < 0) != (den < 0);
      un = (num < 0) ? -num : num;
      ud = (den < 0) ? -den : den;
      q = (un + ud / 2) / ud;
      if (neg) return (q > 64'd16777216) ? -64'sd16777216 : -longint'(q);
      return (q > 64'd16777215) ? 64'sd16777215 : longint'(q);
    endfunction

    function void note_request(logic signed [qrs_pkg::IN_W-1:0] a,
                               logic signed [qrs_pkg::IN_W-1:0] b,
                               logic signed [qrs_pkg::IN_W-1:0] c);
      roots_t r;
      longint sa, sb, sc, d, s, nb;
      sa = a;
      sb = b;
      sc = c;
      d = sb * sb - 4 * sa * sc;
      r.rp = '0;
      r.rm = '0;
      r.disc = d[qrs_pkg::DISC_W-1:0];
      if (sa == 0) begin
        r.status = qrs_pkg::ST_DEGEN;
      end else if (d < 0) begin
        r.status = qrs_pkg::ST_NO_ROOT;
      end else begin
        s = isqrt_scaled(d);
        nb = -sb * (64'sd1 << qrs_pkg::FRAC_BITS_DEF);
        r.status = qrs_pkg::ST_REAL;
        r.rp = qrs_pkg::ROOT_W'(div_round_sat(nb + s, 2 * sa));
        r.rm = qrs_pkg::ROOT_W'(div_round_sat(nb - s, 2 * sa));
      end
      pending_q.push_back(r);
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      n_err++;
    endtask

    task check_result(roots_t got);
      roots_t e;
      if (pending_q.size() == 0) begin
        report("unexpected result");
        return;
      end
      e = pending_q.pop_front();
      if (got.status !== e.status) report($sformatf("status %0d exp %0d", got.status, e.status));
      if (got.disc !== e.disc) report($sformatf("disc %0d exp %0d", got.disc, e.disc));
      if (got.rp !== e.rp) report($sformatf("root_plus %0d exp %0d", got.rp, e.rp));
      if (got.rm !== e.rm) report($sformatf("root_minus %0d exp %0d", got.rm, e.rm));
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int   cycles = 0;
  int   send_idle = 0;
  int   recv_idle = 0;
  bit   hold_off = 1'b0;
  root_scoreboard sb = new();

  qrs_req_if req_if();
  qrs_rsp_if rsp_if();

  quadratic_root_solver_unit i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if.sink),
    .rsp_o  (rsp_if.source)
  );

  always #6 clk_i = ~clk_i;

  initial begin
    req_if.valid = 1'b0;
    req_if.coef_a = '0;
    req_if.coef_b = '0;
    req_if.coef_c = '0;
    rsp_if.ready = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("quadratic_root_solver_unit test failed");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (rsp_if.valid && rsp_if.ready)
        sb.check_result({rsp_if.status, rsp_if.discriminant, rsp_if.root_plus,
                         rsp_if.root_minus});
      rsp_if.ready <= !hold_off && ($urandom_range(99) >= recv_idle);
    end
  end

  task send_request(logic signed [qrs_pkg::IN_W-1:0] a, logic signed [qrs_pkg::IN_W-1:0] b,
                    logic signed [qrs_pkg::IN_W-1:0] c);
    while ($urandom_range(99) < send_idle) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.coef_a <= a;
    req_if.coef_b <= b;
    req_if.coef_c <= c;
    do @(posedge clk_i); while (!req_if.ready);
    sb.note_request(a, b, c);
  endtask

  task send_random;
    logic signed [qrs_pkg::IN_W-1:0] a, b, c;
    int m;
    m = $urandom_range(3);
    a = qrs_pkg::IN_W'($urandom);
    b = qrs_pkg::IN_W'($urandom);
    c = qrs_pkg::IN_W'($urandom);
    if (m == 1) begin
      a = $signed(4'($urandom)) ; b = $signed(8'($urandom)); c = $signed(4'($urandom));
    end else if (m == 2) begin
      c = $signed(qrs_pkg::IN_W'(-$signed(c))) ^ {qrs_pkg::IN_W{a[qrs_pkg::IN_W-1]}};
    end else if (m == 3 && $urandom_range(7) == 0) begin
      a = '0;
    end
    send_request(a, b, c);
  endtask

  task drain;
    req_if.valid <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_request(16'sd1, -16'sd3, 16'sd2);
    send_request(16'sd1, 16'sd0, 16'sd1);
    send_request(16'sd0, 16'sd5, 16'sd7);
    send_request(16'sd0, -16'sd32768, -16'sd32768);
    send_request(-16'sd32768, -16'sd32768, 16'sd32767);
    send_request(16'sd32767, 16'sd32767, -16'sd32768);
    send_request(-16'sd32768, -16'sd32768, -16'sd32768);
    send_request(16'sd32767, 16'sd32767, 16'sd32767);
    send_request(16'sd1, -16'sd32768, -16'sd32768);
    send_request(-16'sd1, 16'sd32767, 16'sd32767);
    send_request(16'sd1, 16'sd2, 16'sd1);
    send_request(16'sd2, 16'sd1, 16'sd0);
    send_request(-16'sd1, 16'sd0, 16'sd0);
    send_request(16'sd4, 16'sd0, -16'sd1);
    send_request(-16'sd1, 16'sd0, 16'sd0);
    send_request(16'sd1, 16'sd0, -16'sd32768);
    send_request(-16'sd1, -16'sd1, -16'sd1);
    drain();

    send_idle = 22;
    recv_idle = 67;
    repeat (140) send_random();
    hold_off = 1'b1;
    fork
      repeat (300) @(posedge clk_i);
      repeat (150) send_random();
    join_any
    hold_off = 1'b0;
    wait fork;
    drain();

    send_idle = 67;
    recv_idle = 22;
    repeat (80) send_random();
    send_idle = 0;
    recv_idle = 0;
    repeat (80) send_random();
    drain();
    repeat (100) @(posedge clk_i);

    if (sb.n_err == 0 && sb.pending_q.size() == 0)
      $display("quadratic_root_solver_unit test passed");
    else
      $display("quadratic_root_solver_unit test failed");
    $finish;
  end
endmodule
